>>> rtl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared sizes, configuration and queue entry types, and helpers for the
// streaming 2D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_KERNEL   = 4;
  localparam int MAX_CHANNELS = 64;
  localparam int SAMPLE_BITS  = 16;

  // Line store banks: one per earlier row that a window can reach back to.
  localparam int BANKS  = MAX_KERNEL - 1;
  localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;

  localparam int POS_W  = $clog2(MAX_WIDTH);
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHN_W  = $clog2(MAX_CHANNELS + 1);
  localparam int KER_W  = $clog2(MAX_KERNEL + 1);
  localparam int STEP_W = 3;

  // Raw register widths.
  localparam int RKER_W  = 3;
  localparam int RSTEP_W = 3;
  localparam int RDIM_W  = 9;
  localparam int RCH_W   = 7;

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    REG_KERNEL_HEIGHT = 3'd0,
    REG_KERNEL_WIDTH  = 3'd1,
    REG_STEP_ROWS     = 3'd2,
    REG_STEP_COLS     = 3'd3,
    REG_IN_HEIGHT     = 3'd4,
    REG_IN_WIDTH      = 3'd5,
    REG_CHANNEL_COUNT = 3'd6
  } reg_idx_t;

  // Configuration after clamping to the supported ranges.
  typedef struct packed {
    logic [KER_W-1:0]  kh;
    logic [KER_W-1:0]  kw;
    logic [STEP_W-1:0] sr;
    logic [STEP_W-1:0] sc;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  w;
    logic [CHN_W-1:0]  chs;
  } cfg_t;

  // One column maximum on its way from the front to the back.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] colmax;
    logic [BANK_W-1:0]      cm;
    logic [KER_W-1:0]       hist_n;
    logic                   emit;
    logic                   last;
    logic [CH_W-1:0]        ch;
    logic [POS_W-1:0]       orow;
    logic [POS_W-1:0]       ocol;
  } entry_t;

  function automatic logic [15:0] clamp_cfg(input logic [15:0] v, input logic [15:0] hi);
    logic [15:0] r;
    if (v == 16'd0) begin
      r = 16'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // (b - d) modulo BANKS, for b and d below BANKS.
  function automatic logic [BANK_W-1:0] bank_sub(input logic [BANK_W-1:0] b,
                                                 input logic [BANK_W-1:0] d);
    logic [BANK_W-1:0] r;
    if (b >= d) begin
      r = b - d;
    end else begin
      r = b + BANK_W'(BANKS) - d;
    end
    return r;
  endfunction

endpackage

>>> rtl/mp2d_ram.sv
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mp2d_front.sv
// ----------------------------------------------------------------------------
// mp2d_front
// Position tracking, window classification and the banked line store; emits
// one column maximum per pixel of a row deep enough for the kernel.
// ----------------------------------------------------------------------------
module mp2d_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mp2d_pkg::cfg_t                      cfg_i,
  input  logic                                restart_i,
  input  logic                                accept_i,
  input  logic [mp2d_pkg::SAMPLE_BITS-1:0]    pixel_i,
  output logic                                s1_valid_o,
  output logic                                push_o,
  output mp2d_pkg::entry_t                    entry_o
);
  import mp2d_pkg::*;

  localparam int LW = DIM_W + 1;

  logic [POS_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [BANK_W-1:0] cm_r, cm_nxt, rm_r, rm_nxt;
  logic [STEP_W-1:0] cph_r, cph_nxt, rph_r, rph_nxt;
  logic [POS_W-1:0]  ocol_r, ocol_nxt, orow_r, orow_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BANKS-1:0]  s1_mask_r, mask;
  entry_t            s1_ent_r, ent;

  logic [SAMPLE_BITS-1:0] rd_data [BANKS];

  logic row_elig, col_elig, col_end, row_end, ch_end, last_row, last_col;
  logic signed [SAMPLE_BITS-1:0] colmax;

  // Line store, one bank per row modulo BANKS, all read at the current column.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    mp2d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_bank (
      .clk   (clk),
      .we    (accept_i && (rm_r == BANK_W'(b))),
      .waddr (col_r),
      .wdata (pixel_i),
      .raddr (col_r),
      .rdata (rd_data[b])
    );
  end

  always_comb begin
    row_elig = ({1'b0, row_r} + DIM_W'(1)) >= DIM_W'(cfg_i.kh);
    col_elig = ({1'b0, col_r} + DIM_W'(1)) >= DIM_W'(cfg_i.kw);
    col_end  = ({1'b0, col_r} + DIM_W'(1)) == cfg_i.w;
    row_end  = ({1'b0, row_r} + DIM_W'(1)) == cfg_i.h;
    ch_end   = ({1'b0, ch_r} + CHN_W'(1)) == cfg_i.chs;
    // No later window start fits below or to the right of this one.
    last_row = (LW'(row_r) + LW'(cfg_i.sr)) >= LW'(cfg_i.h);
    last_col = (LW'(col_r) + LW'(cfg_i.sc)) >= LW'(cfg_i.w);

    // Banks holding the kernel_height - 1 rows above this one. Row r - BANKS
    // shares the bank of the current row and is read before the write lands.
    mask = '0;
    for (int i = 1; i < BANKS + 1; i++) begin
      if (KER_W'(i) < cfg_i.kh) begin
        mask[bank_sub(rm_r, BANK_W'(i % BANKS))] = 1'b1;
      end
    end

    ent.colmax = pixel_i;
    ent.cm     = cm_r;
    ent.hist_n = cfg_i.kw - KER_W'(1);
    ent.emit   = col_elig && (rph_r == '0) && (cph_r == '0);
    ent.last   = ch_end && last_row && last_col;
    ent.ch     = ch_r;
    ent.orow   = orow_r;
    ent.ocol   = ocol_r;
  end

  // Position counters and stride phases.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ch_nxt   = ch_r;
    cm_nxt   = cm_r;
    rm_nxt   = rm_r;
    cph_nxt  = cph_r;
    rph_nxt  = rph_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (restart_i) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ch_nxt   = '0;
      cm_nxt   = '0;
      rm_nxt   = '0;
      cph_nxt  = '0;
      rph_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (accept_i) begin
      if (col_end) begin
        col_nxt  = '0;
        cm_nxt   = '0;
        cph_nxt  = '0;
        ocol_nxt = '0;
        if (row_end) begin
          row_nxt  = '0;
          rm_nxt   = '0;
          rph_nxt  = '0;
          orow_nxt = '0;
          ch_nxt   = ch_end ? '0 : ch_r + CH_W'(1);
        end else begin
          row_nxt = row_r + POS_W'(1);
          rm_nxt  = (rm_r == BANK_W'(BANKS - 1)) ? '0 : rm_r + BANK_W'(1);
          if (row_elig) begin
            rph_nxt  = (rph_r == cfg_i.sr - STEP_W'(1)) ? '0 : rph_r + STEP_W'(1);
            orow_nxt = orow_r + POS_W'(rph_r == '0);
          end
        end
      end else begin
        col_nxt = col_r + POS_W'(1);
        cm_nxt  = (cm_r == BANK_W'(BANKS - 1)) ? '0 : cm_r + BANK_W'(1);
        if (col_elig) begin
          cph_nxt  = (cph_r == cfg_i.sc - STEP_W'(1)) ? '0 : cph_r + STEP_W'(1);
          ocol_nxt = ocol_r + POS_W'(cph_r == '0);
        end
      end
    end
    s1_valid_nxt = accept_i && row_elig && !restart_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      ch_r       <= '0;
      cm_r       <= '0;
      rm_r       <= '0;
      cph_r      <= '0;
      rph_r      <= '0;
      ocol_r     <= '0;
      orow_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      ch_r       <= ch_nxt;
      cm_r       <= cm_nxt;
      rm_r       <= rm_nxt;
      cph_r      <= cph_nxt;
      rph_r      <= rph_nxt;
      ocol_r     <= ocol_nxt;
      orow_r     <= orow_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      s1_ent_r  <= ent;
      s1_mask_r <= mask;
    end
  end

  // The bank reads land now; fold the rows above into the column maximum.
  always_comb begin
    colmax = $signed(s1_ent_r.colmax);
    for (int b = 0; b < BANKS; b++) begin
      if (s1_mask_r[b] && ($signed(rd_data[b]) > colmax)) begin
        colmax = $signed(rd_data[b]);
      end
    end
    entry_o        = s1_ent_r;
    entry_o.colmax = colmax;
  end

  assign push_o     = s1_valid_r;
  assign s1_valid_o = s1_valid_r;

  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(accept_i))
    else $error("column stage valid without an accepted pixel");

endmodule

>>> rtl/mp2d_fifo.sv
// ----------------------------------------------------------------------------
// mp2d_fifo
// Short queue of column maxima between the front and the back.
// ----------------------------------------------------------------------------
module mp2d_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_i,
  input  mp2d_pkg::entry_t          entry_i,
  input  logic                      pop_i,
  output mp2d_pkg::entry_t          head_o,
  output logic                      empty_o,
  output logic [mp2d_pkg::QCNT_W-1:0] count_o
);
  import mp2d_pkg::*;

  entry_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

  assign head_o  = mem_r[rd_ptr_r];
  assign empty_o = (count_r == '0);
  assign count_o = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && !pop_i && (count_r == QCNT_W'(QDEPTH))))
    else $error("column queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("column queue underflow");

endmodule

>>> rtl/mp2d_back.sv
// ----------------------------------------------------------------------------
// mp2d_back
// Keeps the recent column maxima of the row, reduces them across the window
// width and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module mp2d_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty_i,
  input  mp2d_pkg::entry_t                   entry_i,
  output logic                               q_pop_o,
  input  logic                               out_pop_i,
  output logic                               out_valid_o,
  output logic [mp2d_pkg::SAMPLE_BITS-1:0]   max_value_o,
  output logic [mp2d_pkg::CH_W-1:0]          channel_o,
  output logic [mp2d_pkg::POS_W-1:0]         row_o,
  output logic [mp2d_pkg::POS_W-1:0]         col_o,
  output logic                               sample_end_o
);
  import mp2d_pkg::*;

  logic [SAMPLE_BITS-1:0] hist_r [BANKS];
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] max_value_r;
  logic [CH_W-1:0]        channel_r;
  logic [POS_W-1:0]       row_r, col_r;
  logic                   sample_end_r;
  logic                   load;
  logic signed [SAMPLE_BITS-1:0] best;

  always_comb begin
    q_pop_o = !q_empty_i && (!entry_i.emit || !out_valid_r || out_pop_i);
    load    = q_pop_o && entry_i.emit;
    best    = $signed(entry_i.colmax);
    for (int i = 1; i < BANKS + 1; i++) begin
      if (KER_W'(i) <= entry_i.hist_n &&
          $signed(hist_r[bank_sub(entry_i.cm, BANK_W'(i % BANKS))]) > best) begin
        best = $signed(hist_r[bank_sub(entry_i.cm, BANK_W'(i % BANKS))]);
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      hist_r[entry_i.cm] <= entry_i.colmax;
    end
    if (load) begin
      max_value_r  <= best;
      channel_r    <= entry_i.ch;
      row_r        <= entry_i.orow;
      col_r        <= entry_i.ocol;
      sample_end_r <= entry_i.last;
    end
  end

  assign out_valid_o  = out_valid_r;
  assign max_value_o  = max_value_r;
  assign channel_o    = channel_r;
  assign row_o        = row_r;
  assign col_o        = col_r;
  assign sample_end_o = sample_end_r;

endmodule

>>> rtl/max_pool_2d_stream.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2D max pooling over raster-ordered Q8.8 pixels, plane by plane.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Direction  Handshake
//  input     in_pixel_value                          in         push / full
//  result    out_max_value, out_channel, out_row,    out        pop / empty
//            out_col, out_sample_end
//  config    psel, penable, pwrite, paddr, pwdata,   in/out     APB, pready tied high
//            prdata, pready
//
//  One pixel request is taken every cycle while full is low. A result passes
//  through the bank read stage and then the column queue before it reaches
//  the output register and the output ports.
//  full rises when the four-entry column queue plus the request in the bank
//  read stage would fill it; it is set by result backpressure alone.
//  Reset is synchronous; the line store banks are not cleared, since a plane
//  only reads rows written earlier in the same plane.
//  Any write to a decoded register restarts the stream at channel 0, row 0, column 0.
//
module max_pool_2d_stream (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Pixel input
  input  logic                                 push,
  output logic                                 full,
  input  logic [mp2d_pkg::SAMPLE_BITS-1:0]     in_pixel_value,
  // Pooled results
  output logic                                 empty,
  input  logic                                 pop,
  output logic [mp2d_pkg::SAMPLE_BITS-1:0]     out_max_value,
  output logic [mp2d_pkg::CH_W-1:0]            out_channel,
  output logic [mp2d_pkg::POS_W-1:0]           out_row,
  output logic [mp2d_pkg::POS_W-1:0]           out_col,
  output logic                                 out_sample_end,
  // Register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mp2d_pkg::APB_AW-1:0]          paddr,
  input  logic [mp2d_pkg::APB_DW-1:0]          pwdata,
  output logic [mp2d_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import mp2d_pkg::*;

  // Raw register contents, as written.
  logic [RKER_W-1:0]  kh_r, kh_nxt, kw_r, kw_nxt;
  logic [RSTEP_W-1:0] sr_r, sr_nxt, sc_r, sc_nxt;
  logic [RDIM_W-1:0]  h_r, h_nxt, w_r, w_nxt;
  logic [RCH_W-1:0]   chs_r, chs_nxt;

  reg_idx_t  reg_idx;
  logic      cfg_wr;
  logic      restart;
  cfg_t      cfg;

  logic      accept;
  logic      s1_valid;
  logic      q_push, q_pop, q_empty;
  entry_t    q_entry, q_head;
  logic [QCNT_W-1:0] q_count;
  logic      out_valid;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes; an address past the last register is ignored and does
  // not restart the stream.
  always_comb begin
    kh_nxt  = kh_r;
    kw_nxt  = kw_r;
    sr_nxt  = sr_r;
    sc_nxt  = sc_r;
    h_nxt   = h_r;
    w_nxt   = w_r;
    chs_nxt = chs_r;
    restart = 1'b0;
    if (cfg_wr) begin
      restart = 1'b1;
      case (reg_idx)
        REG_KERNEL_HEIGHT: kh_nxt  = pwdata[RKER_W-1:0];
        REG_KERNEL_WIDTH:  kw_nxt  = pwdata[RKER_W-1:0];
        REG_STEP_ROWS:     sr_nxt  = pwdata[RSTEP_W-1:0];
        REG_STEP_COLS:     sc_nxt  = pwdata[RSTEP_W-1:0];
        REG_IN_HEIGHT:     h_nxt   = pwdata[RDIM_W-1:0];
        REG_IN_WIDTH:      w_nxt   = pwdata[RDIM_W-1:0];
        REG_CHANNEL_COUNT: chs_nxt = pwdata[RCH_W-1:0];
        default:           restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_r  <= RKER_W'(2);
      kw_r  <= RKER_W'(2);
      sr_r  <= RSTEP_W'(2);
      sc_r  <= RSTEP_W'(2);
      h_r   <= RDIM_W'(32);
      w_r   <= RDIM_W'(32);
      chs_r <= RCH_W'(1);
    end else begin
      kh_r  <= kh_nxt;
      kw_r  <= kw_nxt;
      sr_r  <= sr_nxt;
      sc_r  <= sc_nxt;
      h_r   <= h_nxt;
      w_r   <= w_nxt;
      chs_r <= chs_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KERNEL_HEIGHT: prdata = APB_DW'(kh_r);
      REG_KERNEL_WIDTH:  prdata = APB_DW'(kw_r);
      REG_STEP_ROWS:     prdata = APB_DW'(sr_r);
      REG_STEP_COLS:     prdata = APB_DW'(sc_r);
      REG_IN_HEIGHT:     prdata = APB_DW'(h_r);
      REG_IN_WIDTH:      prdata = APB_DW'(w_r);
      REG_CHANNEL_COUNT: prdata = APB_DW'(chs_r);
      default:           prdata = '0;
    endcase
  end

  // Zero means one; kernel, plane size and channel count saturate at the
  // supported maximum.
  always_comb begin
    cfg.kh  = KER_W'(clamp_cfg(16'(kh_r), 16'(MAX_KERNEL)));
    cfg.kw  = KER_W'(clamp_cfg(16'(kw_r), 16'(MAX_KERNEL)));
    cfg.sr  = STEP_W'(clamp_cfg(16'(sr_r), 16'(7)));
    cfg.sc  = STEP_W'(clamp_cfg(16'(sc_r), 16'(7)));
    cfg.h   = DIM_W'(clamp_cfg(16'(h_r), 16'(MAX_WIDTH)));
    cfg.w   = DIM_W'(clamp_cfg(16'(w_r), 16'(MAX_WIDTH)));
    cfg.chs = CHN_W'(clamp_cfg(16'(chs_r), 16'(MAX_CHANNELS)));
  end

  // The queue must have room for the request in the bank read stage and for
  // one more, so full depends on registered counts only.
  assign full   = ({1'b0, q_count} + (QCNT_W + 1)'(s1_valid)) >= (QCNT_W + 1)'(QDEPTH);
  assign accept = push && !full;

  mp2d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .restart_i  (restart),
    .accept_i   (accept),
    .pixel_i    (in_pixel_value),
    .s1_valid_o (s1_valid),
    .push_o     (q_push),
    .entry_o    (q_entry)
  );

  mp2d_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  mp2d_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty_i    (q_empty),
    .entry_i      (q_head),
    .q_pop_o      (q_pop),
    .out_pop_i    (pop && out_valid),
    .out_valid_o  (out_valid),
    .max_value_o  (out_max_value),
    .channel_o    (out_channel),
    .row_o        (out_row),
    .col_o        (out_col),
    .sample_end_o (out_sample_end)
  );

  assign empty = !out_valid;

endmodule

>>> tb/sv/max_pool_2d_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream_tb
// Self-checking bench for the streaming 2D max pooling block. A directed table
// covers the pixel extremes and the special configurations. Random phases
// follow, each with its own register setting and pixel stream. Every pooled
// result is compared field by field against a behavioral model of the pooling
// held in this file, or against a result written out in the directed table.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_tb;
  import mp2d_pkg::*;

  // Register index that the block does not decode; a write there must be
  // ignored and must not restart the stream.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // The receiver holds off this long once, so that the column queue fills up
  // and full throttles the pixel requests.
  localparam int unsigned HOLD_CYCLES = 200;

  // Random stimulus length, and the point after which neither side idles.
  localparam int unsigned RANDOM_PIXELS = 700;
  localparam int unsigned CALM_AFTER    = 600;

  // Cycles allowed after the last expected result before the block counts as
  // idle: bank read, column queue and output register, with some margin.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [CH_W-1:0]               channel;
    logic [POS_W-1:0]              row;
    logic [POS_W-1:0]              col;
    logic                          sample_end;
  } pool_result_t;

  typedef enum logic {ROW_CONFIG, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic [2:0]                    reg_index;
    int unsigned                   value;
    logic signed [SAMPLE_BITS-1:0] pixel;
    bit                            typed;
    pool_result_t                  typed_result;
  } directed_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   push           = 1'b0;
  logic                   full;
  logic [SAMPLE_BITS-1:0] in_pixel_value = '0;

  logic                   empty;
  logic                   pop            = 1'b0;
  logic [SAMPLE_BITS-1:0] out_max_value;
  logic [CH_W-1:0]        out_channel;
  logic [POS_W-1:0]       out_row;
  logic [POS_W-1:0]       out_col;
  logic                   out_sample_end;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_AW-1:0]      paddr   = '0;
  logic [APB_DW-1:0]      pwdata  = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  always #2 clk = ~clk;

  max_pool_2d_stream u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_pixel_value (in_pixel_value),
    .empty          (empty),
    .pop            (pop),
    .out_max_value  (out_max_value),
    .out_channel    (out_channel),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_sample_end (out_sample_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Pooling model. The register values are kept raw, as written, and clamped
  // on use, just as the block is expected to clamp them. The line buffer and
  // the column maximum history start at zero; the stimulus never reads an
  // entry that was not written earlier in the same plane.
  // --------------------------------------------------------------------------
  logic [RKER_W-1:0]  raw_kh  = 3'd2;
  logic [RKER_W-1:0]  raw_kw  = 3'd2;
  logic [RSTEP_W-1:0] raw_sr  = 3'd2;
  logic [RSTEP_W-1:0] raw_sc  = 3'd2;
  logic [RDIM_W-1:0]  raw_h   = 9'd32;
  logic [RDIM_W-1:0]  raw_w   = 9'd32;
  logic [RCH_W-1:0]   raw_chs = 7'd1;

  bit signed [SAMPLE_BITS-1:0] line_buf [BANKS][MAX_WIDTH];
  bit signed [SAMPLE_BITS-1:0] colmax_hist [BANKS];
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;
  int unsigned cur_ch  = 0;

  // Expected results, oldest first.
  pool_result_t pooled_q[$];

  int unsigned mismatches    = 0;
  int unsigned hold_requests = 0;
  bit          calm          = 1'b0;

  // Zero means one; anything above the supported range saturates.
  function automatic int unsigned bound_cfg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // A register write lands at once and restarts the stream at the first
  // pixel of channel 0. Writes to an undecoded index change nothing.
  function automatic void load_setting(input logic [2:0] idx, input int unsigned val);
    case (idx)
      REG_KERNEL_HEIGHT: raw_kh  = val[RKER_W-1:0];
      REG_KERNEL_WIDTH:  raw_kw  = val[RKER_W-1:0];
      REG_STEP_ROWS:     raw_sr  = val[RSTEP_W-1:0];
      REG_STEP_COLS:     raw_sc  = val[RSTEP_W-1:0];
      REG_IN_HEIGHT:     raw_h   = val[RDIM_W-1:0];
      REG_IN_WIDTH:      raw_w   = val[RDIM_W-1:0];
      REG_CHANNEL_COUNT: raw_chs = val[RCH_W-1:0];
      default:           return;
    endcase
    cur_col = 0;
    cur_row = 0;
    cur_ch  = 0;
  endfunction

  // Takes one pixel and returns 1 with the pooled result when that pixel
  // closes the bottom-right corner of a window.
  function automatic bit pool_pixel(input logic signed [SAMPLE_BITS-1:0] px,
                                    output pool_result_t res);
    int unsigned kh, kw, sr, sc, h, w, chs;
    int unsigned r, c, ch, orow, ocol;
    logic signed [SAMPLE_BITS-1:0] colmax, best, v;
    bit emitted;
    kh  = bound_cfg(raw_kh, MAX_KERNEL);
    kw  = bound_cfg(raw_kw, MAX_KERNEL);
    sr  = bound_cfg(raw_sr, 7);
    sc  = bound_cfg(raw_sc, 7);
    h   = bound_cfg(raw_h, MAX_WIDTH);
    w   = bound_cfg(raw_w, MAX_WIDTH);
    chs = bound_cfg(raw_chs, MAX_CHANNELS);
    r = cur_row;
    c = cur_col;
    ch = cur_ch;
    emitted = 1'b0;
    res = '0;
    if (r >= h || c >= w || ch >= chs) begin
      r = 0;
      c = 0;
      ch = 0;
    end
    // Once enough rows are in, fold this column over the kernel height; the
    // earlier rows come from the line buffer banks.
    if (r + 1 >= kh) begin
      colmax = px;
      for (int unsigned i = 1; i < kh; i++) begin
        v = line_buf[(r - i) % BANKS][c];
        if (v > colmax) colmax = v;
      end
      // A window closes here only on the row and column step grids.
      if (c + 1 >= kw && (r + 1 - kh) % sr == 0 && (c + 1 - kw) % sc == 0) begin
        best = colmax;
        orow = (r + 1 - kh) / sr;
        ocol = (c + 1 - kw) / sc;
        for (int unsigned i = 1; i < kw; i++) begin
          v = colmax_hist[(c - i) % BANKS];
          if (v > best) best = v;
        end
        res.max_value  = best;
        res.channel    = CH_W'(ch);
        res.row        = POS_W'(orow);
        res.col        = POS_W'(ocol);
        res.sample_end = (ch + 1 == chs) && kh <= h && kw <= w &&
                         orow == (h - kh) / sr && ocol == (w - kw) / sc;
        emitted = 1'b1;
      end
      colmax_hist[c % BANKS] = colmax;
    end
    line_buf[r % BANKS][c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        ch++;
        if (ch >= chs) ch = 0;
      end
    end
    cur_col = c;
    cur_row = r;
    cur_ch  = ch;
    return emitted;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders.
  // --------------------------------------------------------------------------
  function automatic directed_row_t cfg_row(input logic [2:0] idx, input int unsigned val);
    directed_row_t row;
    row.kind         = ROW_CONFIG;
    row.reg_index    = idx;
    row.value        = val;
    row.pixel        = '0;
    row.typed        = 1'b0;
    row.typed_result = '0;
    return row;
  endfunction

  function automatic directed_row_t pix_row(input logic signed [SAMPLE_BITS-1:0] px);
    directed_row_t row;
    row.kind         = ROW_PIXEL;
    row.reg_index    = '0;
    row.value        = 0;
    row.pixel        = px;
    row.typed        = 1'b0;
    row.typed_result = '0;
    return row;
  endfunction

  // A pixel row whose pooled result is written out in full.
  function automatic directed_row_t pix_known(input logic signed [SAMPLE_BITS-1:0] px,
                                              input logic signed [SAMPLE_BITS-1:0] mv,
                                              input int unsigned ch, input int unsigned r,
                                              input int unsigned c, input bit last);
    directed_row_t row;
    row = pix_row(px);
    row.typed                   = 1'b1;
    row.typed_result.max_value  = mv;
    row.typed_result.channel    = CH_W'(ch);
    row.typed_result.row        = POS_W'(r);
    row.typed_result.col        = POS_W'(c);
    row.typed_result.sample_end = last;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Request side tasks.
  // --------------------------------------------------------------------------

  // Offers one pixel request, possibly after an idle burst, and waits until
  // the block takes it. The model runs at the accepting edge, well ahead of
  // the result, which trails it through the bank read stage and the output register.
  task automatic send_pixel(input logic signed [SAMPLE_BITS-1:0] px, input bit typed,
                            input pool_result_t typed_result);
    int unsigned gap;
    pool_result_t res;
    bit emitted;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_pixel_value <= px;
    do @(posedge clk); while (full !== 1'b0);
    emitted = pool_pixel(px, res);
    if (typed) begin
      pooled_q.push_back(typed_result);
    end else if (emitted) begin
      pooled_q.push_back(res);
    end
  endtask

  // Stops offering pixels and waits until every pooled result has been taken.
  // A pixel that closes no window leaves nothing in the queue, so the pipeline
  // is given SETTLE_CYCLES to empty before the block is treated as idle.
  task automatic drain_results();
    push <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase, then the access phase until pready, then an
  // idle phase so that the next write starts with a setup phase of its own.
  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    load_setting(idx, val);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: pops with random stall bursts, one long hold-off when the
  // request side asks for it, and checks every result taken.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int unsigned stall;
    int unsigned holds_seen;
    pool_result_t want;
    stall = 0;
    holds_seen = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && empty === 1'b0) begin
        if (pooled_q.size() == 0) begin
          mismatches++;
          $error("result with no pixel request behind it: max %0d ch %0d row %0d col %0d",
                 $signed(out_max_value), out_channel, out_row, out_col);
        end else begin
          want = pooled_q.pop_front();
          if (out_max_value !== want.max_value) begin
            mismatches++;
            $error("out_max_value: expected %0d, got %0d",
                   want.max_value, $signed(out_max_value));
          end
          if (out_channel !== want.channel) begin
            mismatches++;
            $error("out_channel: expected %0d, got %0d", want.channel, out_channel);
          end
          if (out_row !== want.row) begin
            mismatches++;
            $error("out_row: expected %0d, got %0d", want.row, out_row);
          end
          if (out_col !== want.col) begin
            mismatches++;
            $error("out_col: expected %0d, got %0d", want.col, out_col);
          end
          if (out_sample_end !== want.sample_end) begin
            mismatches++;
            $error("out_sample_end: expected %0d, got %0d", want.sample_end, out_sample_end);
          end
        end
      end
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(1, 12) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side: reset, directed table, random phases, then the verdict.
  // --------------------------------------------------------------------------
  initial begin : request_side
    directed_row_t directed_rows[$];
    int unsigned kh, kw, sr, sc, h, w, chs;
    int unsigned count, sample, phase, pixels_sent;
    logic signed [SAMPLE_BITS-1:0] px;

    // A 1x1 kernel with unit steps over a 2x2 plane passes each pixel
    // through, so the extremes come back unchanged. The undecoded write in
    // the middle must not disturb the raster position.
    directed_rows.push_back(cfg_row(REG_KERNEL_HEIGHT, 1));
    directed_rows.push_back(cfg_row(REG_KERNEL_WIDTH, 1));
    directed_rows.push_back(cfg_row(REG_STEP_ROWS, 1));
    directed_rows.push_back(cfg_row(REG_STEP_COLS, 1));
    directed_rows.push_back(cfg_row(REG_IN_HEIGHT, 2));
    directed_rows.push_back(cfg_row(REG_IN_WIDTH, 2));
    directed_rows.push_back(cfg_row(REG_CHANNEL_COUNT, 1));
    directed_rows.push_back(pix_known(16'sh8000, 16'sh8000, 0, 0, 0, 1'b0));
    directed_rows.push_back(pix_known(16'sh7FFF, 16'sh7FFF, 0, 0, 1, 1'b0));
    directed_rows.push_back(cfg_row(REG_UNUSED, 3));
    directed_rows.push_back(pix_known(16'sh0000, 16'sh0000, 0, 1, 0, 1'b0));
    directed_rows.push_back(pix_known(16'shFFFF, 16'shFFFF, 0, 1, 1, 1'b1));
    // One 2x2 window over the whole 2x2 plane: the maximum positive value wins
    // over the most negative one.
    directed_rows.push_back(cfg_row(REG_KERNEL_HEIGHT, 2));
    directed_rows.push_back(cfg_row(REG_KERNEL_WIDTH, 2));
    directed_rows.push_back(pix_row(16'sd5));
    directed_rows.push_back(pix_row(-16'sd7));
    directed_rows.push_back(pix_row(16'sh7FFF));
    directed_rows.push_back(pix_known(16'sh8000, 16'sh7FFF, 0, 0, 0, 1'b1));
    // Zeros read as one and an oversized kernel width saturates to four:
    // a 1x4 window sliding over one row of five.
    directed_rows.push_back(cfg_row(REG_KERNEL_HEIGHT, 0));
    directed_rows.push_back(cfg_row(REG_KERNEL_WIDTH, 7));
    directed_rows.push_back(cfg_row(REG_STEP_ROWS, 0));
    directed_rows.push_back(cfg_row(REG_STEP_COLS, 0));
    directed_rows.push_back(cfg_row(REG_IN_HEIGHT, 0));
    directed_rows.push_back(cfg_row(REG_IN_WIDTH, 5));
    directed_rows.push_back(cfg_row(REG_CHANNEL_COUNT, 0));
    directed_rows.push_back(pix_row(16'sd100));
    directed_rows.push_back(pix_row(-16'sd3));
    directed_rows.push_back(pix_row(16'sd7));
    directed_rows.push_back(pix_row(16'sd40));
    directed_rows.push_back(pix_row(16'sh8000));
    // Kernel taller than the plane: no window fits, and the stream is cut
    // off mid-plane by the next write.
    directed_rows.push_back(cfg_row(REG_KERNEL_HEIGHT, 4));
    directed_rows.push_back(cfg_row(REG_KERNEL_WIDTH, 1));
    directed_rows.push_back(cfg_row(REG_IN_HEIGHT, 3));
    directed_rows.push_back(cfg_row(REG_IN_WIDTH, 2));
    directed_rows.push_back(pix_row(16'sd9));
    directed_rows.push_back(pix_row(16'sh7FFF));
    directed_rows.push_back(pix_row(-16'sd9));
    // Steps longer than the kernel: the pixels in between feed no window.
    directed_rows.push_back(cfg_row(REG_KERNEL_HEIGHT, 1));
    directed_rows.push_back(cfg_row(REG_STEP_ROWS, 3));
    directed_rows.push_back(cfg_row(REG_STEP_COLS, 4));
    directed_rows.push_back(cfg_row(REG_IN_HEIGHT, 1));
    directed_rows.push_back(cfg_row(REG_IN_WIDTH, 5));
    directed_rows.push_back(pix_row(16'sd11));
    directed_rows.push_back(pix_row(16'sd12));
    directed_rows.push_back(pix_row(16'sd13));
    directed_rows.push_back(pix_row(16'sd14));
    directed_rows.push_back(pix_row(16'sd15));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain_results();
        write_reg(directed_rows[i].reg_index, directed_rows[i].value);
      end else begin
        send_pixel(directed_rows[i].pixel, directed_rows[i].typed,
                   directed_rows[i].typed_result);
      end
    end

    // Random phases. The first few are fixed corner settings: a pass-through
    // stream while the receiver holds off, the widest plane, the most
    // channels, the tallest plane, and the largest kernel with the longest
    // steps. The rest draw every register at random, mostly over small planes
    // so that whole samples and their last results come by often.
    phase = 0;
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      drain_results();
      case (phase)
        0: begin
          kh = 1; kw = 1; sr = 1; sc = 1; h = 4; w = 8; chs = 1; count = 64;
        end
        1: begin
          kh = 1; kw = 1; sr = 1; sc = 1; h = 1; w = 511; chs = 1; count = 256;
        end
        2: begin
          kh = 1; kw = 1; sr = 1; sc = 1; h = 1; w = 1; chs = 64; count = 64;
        end
        3: begin
          kh = 4; kw = 2; sr = 4; sc = 1; h = 256; w = 2; chs = 2; count = 40;
        end
        4: begin
          kh = 4; kw = 4; sr = 7; sc = 7; h = 5; w = 12; chs = 1; count = 60;
        end
        default: begin
          kh = $urandom_range(0, 7);
          kw = $urandom_range(0, 7);
          sr = $urandom_range(0, 7);
          sc = $urandom_range(0, 7);
          h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 6);
          w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 6);
          chs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 3);
          sample = bound_cfg(h, MAX_WIDTH) * bound_cfg(w, MAX_WIDTH) *
                   bound_cfg(chs, MAX_CHANNELS);
          count = (sample <= 40) ? sample * $urandom_range(1, 2) : $urandom_range(8, 40);
          // Now and then the stream is cut off partway, so that the next
          // write lands mid-plane.
          if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
        end
      endcase
      write_reg(REG_KERNEL_HEIGHT, kh);
      write_reg(REG_KERNEL_WIDTH, kw);
      write_reg(REG_STEP_ROWS, sr);
      write_reg(REG_STEP_COLS, sc);
      write_reg(REG_IN_HEIGHT, h);
      write_reg(REG_IN_WIDTH, w);
      write_reg(REG_CHANNEL_COUNT, chs);
      // Every pixel yields a result in the pass-through phase, so a long
      // receiver hold-off backs the block up into full.
      if (phase == 0) hold_requests++;
      repeat (count) begin
        case ($urandom_range(0, 5))
          0:       px = 16'sh8000;
          1:       px = 16'sh7FFF;
          2:       px = $signed(16'($urandom_range(0, 31))) - 16'sd16;
          default: px = $signed(16'($urandom));
        endcase
        send_pixel(px, 1'b0, '0);
        pixels_sent++;
        calm = (pixels_sent >= CALM_AFTER);
      end
      phase++;
    end

    drain_results();
    if (mismatches == 0) begin
      $display("max_pool_2d_stream_tb passed");
    end else begin
      $display("max_pool_2d_stream_tb failed");
    end
    $finish;
  end

  // The whole run ends well before this bound, even with every stall at its
  // longest.
  initial begin : watchdog
    #2_000_000;
    $display("max_pool_2d_stream_tb failed");
    $finish;
  end

endmodule
